[design/owbm_pkg.sv]
package owbm_pkg;

    // configuration register map, index = paddr[4:2]
    localparam int CFG_NUM = 8;
    localparam int CFG_BITS = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_LOW     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_LOW      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_RECOVERY = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_WAIT   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_READ_TAIL     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESET_LOW     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESENCE_WAIT = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESET_TAIL    = 3'd7;

    typedef logic [CFG_NUM-1:0][CFG_BITS-1:0] owbm_cfg_t;

    // highest index first
    localparam owbm_cfg_t CFG_RESET_VALUES = {
        16'd4100, 16'd700, 16'd4800, 16'd550, 16'd90, 16'd100, 16'd600, 16'd60
    };

    // command kinds
    localparam logic [2:0] KIND_RESET      = 3'd0;
    localparam logic [2:0] KIND_WRITE_BIT  = 3'd1;
    localparam logic [2:0] KIND_READ_BIT   = 3'd2;
    localparam logic [2:0] KIND_WRITE_BYTE = 3'd3;
    localparam logic [2:0] KIND_READ_BYTE  = 3'd4;
    localparam logic [2:0] KIND_TOUCH_BYTE = 3'd5;

    localparam logic [2:0] LAST_BIT_INDEX = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_LOW  = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_TAIL = 4'b1000
    } owbm_phase_t;

    typedef enum logic [1:0] {
        SLOT_RESET = 2'd0,
        SLOT_ONE   = 2'd1,
        SLOT_ZERO  = 2'd2
    } owbm_slot_t;

    typedef struct packed {
        logic       start_req;
        logic [2:0] kind;
        logic [7:0] data_in;
        logic       bus_level;
        logic       tick;
    } owbm_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       no_presence;
    } owbm_result_t;

endpackage

[design/owbm_cfg_regs.sv]
module owbm_cfg_regs (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output owbm_pkg::owbm_cfg_t   cfg
);
    import owbm_pkg::*;

    owbm_cfg_t cfg_reg;
    owbm_cfg_t cfg_next;

    logic [CFG_IDX_BITS-1:0] idx;

    assign idx   = paddr[4:2];
    assign pready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            cfg_next[idx] = pwdata[CFG_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET_VALUES;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign prdata = {{(32-CFG_BITS){1'b0}}, cfg_reg[idx]};
    assign cfg    = cfg_reg;

endmodule

[design/owbm_engine.sv]
module owbm_engine #(
    parameter int TICK_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  owbm_pkg::owbm_cfg_t   cfg,
    input  logic                  step,
    input  owbm_pkg::owbm_item_t  item,
    output owbm_pkg::owbm_result_t result
);
    import owbm_pkg::*;

    localparam int CMP_BITS = (TICK_BITS > CFG_BITS) ? TICK_BITS : CFG_BITS;
    localparam logic [CMP_BITS-1:0] CNT_MAX = CMP_BITS'({TICK_BITS{1'b1}});

    owbm_phase_t          phase_reg,   phase_next;
    logic [TICK_BITS-1:0] count_reg,   count_next;
    logic [2:0]           bit_idx_reg, bit_idx_next;
    logic [7:0]           send_reg,    send_next;
    logic [7:0]           recv_reg,    recv_next;
    logic [2:0]           kind_reg,    kind_next;
    logic                 presence_reg, presence_next;

    owbm_slot_t           slot;
    logic [CFG_BITS-1:0]  target_raw;
    logic [CMP_BITS-1:0]  target_wide;
    logic [TICK_BITS-1:0] target;
    logic                 done;

    // slot kind follows the command and the next bit to send
    always_comb begin
        if (kind_reg == KIND_RESET) begin
            slot = SLOT_RESET;
        end else if (kind_reg == KIND_READ_BIT || kind_reg == KIND_READ_BYTE) begin
            slot = SLOT_ONE;
        end else if (send_reg[0]) begin
            slot = SLOT_ONE;
        end else begin
            slot = SLOT_ZERO;
        end
    end

    always_comb begin
        case (phase_reg)
            PH_LOW: begin
                if (slot == SLOT_RESET)    target_raw = cfg[CFG_RESET_LOW];
                else if (slot == SLOT_ONE) target_raw = cfg[CFG_SHORT_LOW];
                else                       target_raw = cfg[CFG_LONG_LOW];
            end
            PH_WAIT: begin
                if (slot == SLOT_RESET) target_raw = cfg[CFG_PRESENCE_WAIT];
                else                    target_raw = cfg[CFG_SAMPLE_WAIT];
            end
            default: begin
                if (slot == SLOT_RESET)    target_raw = cfg[CFG_RESET_TAIL];
                else if (slot == SLOT_ONE) target_raw = cfg[CFG_READ_TAIL];
                else                       target_raw = cfg[CFG_ZERO_RECOVERY];
            end
        endcase
        // targets beyond the counter range saturate
        target_wide = CMP_BITS'(target_raw);
        if (target_wide > CNT_MAX) begin
            target = TICK_BITS'(CNT_MAX);
        end else begin
            target = TICK_BITS'(target_wide);
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        bit_idx_next  = bit_idx_reg;
        send_next     = send_reg;
        recv_next     = recv_reg;
        kind_next     = kind_reg;
        presence_next = presence_reg;
        done          = 1'b0;

        if (step) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (item.start_req && item.kind <= KIND_TOUCH_BYTE) begin
                        kind_next    = item.kind;
                        send_next    = item.data_in;
                        bit_idx_next = '0;
                        count_next   = '0;
                        phase_next   = PH_LOW;
                    end
                end
                PH_LOW, PH_WAIT, PH_TAIL: begin
                    if (count_reg >= target) begin
                        count_next = '0;
                        if (phase_reg == PH_LOW) begin
                            phase_next = (slot == SLOT_ZERO) ? PH_TAIL : PH_WAIT;
                        end else if (phase_reg == PH_WAIT) begin
                            if (slot == SLOT_RESET) begin
                                presence_next = ~item.bus_level;
                            end else if (kind_reg == KIND_READ_BIT) begin
                                recv_next = {7'b0, item.bus_level};
                            end else if (kind_reg == KIND_READ_BYTE ||
                                         kind_reg == KIND_TOUCH_BYTE) begin
                                recv_next = {item.bus_level, recv_reg[7:1]};
                            end
                            phase_next = PH_TAIL;
                        end else begin
                            // touch with a zero slot shifts in a zero
                            if (kind_reg == KIND_TOUCH_BYTE && slot == SLOT_ZERO) begin
                                recv_next = {1'b0, recv_reg[7:1]};
                            end
                            if ((kind_reg == KIND_WRITE_BYTE || kind_reg == KIND_READ_BYTE ||
                                 kind_reg == KIND_TOUCH_BYTE) &&
                                bit_idx_reg != LAST_BIT_INDEX) begin
                                bit_idx_next = bit_idx_reg + 3'd1;
                                send_next    = {1'b0, send_reg[7:1]};
                                phase_next   = PH_LOW;
                            end else begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                        end
                    end else if (item.tick && count_reg != {TICK_BITS{1'b1}}) begin
                        count_next = count_reg + TICK_BITS'(1);
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            bit_idx_reg  <= '0;
            send_reg     <= '0;
            recv_reg     <= '0;
            kind_reg     <= '0;
            presence_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            bit_idx_reg  <= bit_idx_next;
            send_reg     <= send_next;
            recv_reg     <= recv_next;
            kind_reg     <= kind_next;
            presence_reg <= presence_next;
        end
    end

    always_comb begin
        result.drive_low   = (phase_next == PH_LOW);
        result.busy_res    = (phase_next != PH_IDLE);
        result.done_res    = done;
        result.read_data   = recv_next;
        result.no_presence = ~presence_next;
    end

endmodule

[design/one_wire_bus_master_unit.sv]
// an accepted word waits in the input register; its engine step then loads the result register
// throughput: one word per cycle while result words are taken (m_tready high)
// while a result word waits, one more input word is held and then s_tready drops
// reset: aresetn synchronous, active low; engine idle, counters and shifters cleared,
// no_presence reads 1 until a reset command, timing registers back to their defaults
module one_wire_bus_master_unit #(
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] start_req, [8:1] data_in, [9] bus_level, [10] tick, [15:11] zero
    input  logic [15:0] s_tdata,
    // [2:0] kind
    input  logic [2:0]  s_tuser,

    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data,
    // [11] no_presence, [15:12] zero
    output logic [15:0] m_tdata,

    // timing register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import owbm_pkg::*;

    owbm_cfg_t    cfg;

    // input register
    logic         in_valid_reg, in_valid_next;
    owbm_item_t   in_item_reg;

    // result register
    logic         out_valid_reg, out_valid_next;
    owbm_result_t out_res_reg;

    owbm_result_t res;
    logic         out_free;
    logic         step;

    owbm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the result register frees up when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_tready;
    // an engine step consumes the held word and fills the result register
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    owbm_engine #(
        .TICK_BITS (TICK_COUNT_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .item    (in_item_reg),
        .result  (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.start_req <= s_tdata[0];
            in_item_reg.kind      <= s_tuser;
            in_item_reg.data_in   <= s_tdata[8:1];
            in_item_reg.bus_level <= s_tdata[9];
            in_item_reg.tick      <= s_tdata[10];
        end
        if (step) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_res_reg.no_presence, out_res_reg.read_data,
                       out_res_reg.done_res, out_res_reg.busy_res, out_res_reg.drive_low};

endmodule

[tb/tb_top.sv]
module tb_top;
    import owbm_pkg::*;

    // kinds outside the command set, the master must stay idle on them
    localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

    localparam int CYCLE_LIMIT = 200_000;
    // words of filler pushed at a time while waiting for a command to finish
    localparam int FILL_CHUNK  = 16;

    // how the bus level is driven on filler and command words
    typedef enum logic [1:0] {
        BUS_LOW,
        BUS_HIGH,
        BUS_RANDOM
    } bus_drive_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [0] start_req, [8:1] data_in, [9] bus_level, [10] tick, [15:11] zero
    logic [15:0] s_tdata  = '0;
    // [2:0] kind
    logic [2:0]  s_tuser  = '0;

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data,
    // [11] no_presence, [15:12] zero
    logic [15:0] m_tdata;

    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    one_wire_bus_master_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // bus master shadow: phase engine, counters, shifters and timings
    // ------------------------------------------------------------------
    owbm_phase_t  ow_phase;
    logic [15:0]  ow_ticks;
    logic [2:0]   ow_bit;
    logic [7:0]   ow_tx;
    logic [7:0]   ow_rx;
    logic [2:0]   ow_kind;
    logic         ow_presence;
    logic [15:0]  ow_timing [CFG_NUM];

    owbm_item_t   tx_words [$];          // words waiting for the driver
    owbm_result_t master_outputs_due [$]; // predicted output words, oldest first
    int           words_unaccepted = 0;   // queued or on the bus, not yet taken
    int           mismatches = 0;
    int           results_seen = 0;
    int           cycle_count = 0;

    // one engine step of the master: returns the outputs after this step's update
    function automatic owbm_result_t advance_master(owbm_item_t w);
        owbm_slot_t   slot;
        logic [15:0]  target;
        owbm_result_t r;
        r.done_res = 1'b0;
        if (ow_phase == PH_IDLE) begin
            // unknown kinds are dropped, master stays idle
            if (w.start_req && w.kind <= KIND_TOUCH_BYTE) begin
                ow_kind  = w.kind;
                ow_tx    = w.data_in;
                ow_bit   = '0;
                ow_ticks = '0;
                ow_phase = PH_LOW;
            end
        end else begin
            // read slots share the write-one timing
            if (ow_kind == KIND_RESET)
                slot = SLOT_RESET;
            else if (ow_kind == KIND_READ_BIT || ow_kind == KIND_READ_BYTE)
                slot = SLOT_ONE;
            else
                slot = ow_tx[0] ? SLOT_ONE : SLOT_ZERO;
            case (ow_phase)
                PH_LOW:  target = (slot == SLOT_RESET) ? ow_timing[CFG_RESET_LOW] :
                                  (slot == SLOT_ONE)   ? ow_timing[CFG_SHORT_LOW] :
                                                         ow_timing[CFG_LONG_LOW];
                PH_WAIT: target = (slot == SLOT_RESET) ? ow_timing[CFG_PRESENCE_WAIT] :
                                                         ow_timing[CFG_SAMPLE_WAIT];
                default: target = (slot == SLOT_RESET) ? ow_timing[CFG_RESET_TAIL] :
                                  (slot == SLOT_ONE)   ? ow_timing[CFG_READ_TAIL] :
                                                         ow_timing[CFG_ZERO_RECOVERY];
            endcase
            if (ow_ticks >= target) begin
                ow_ticks = '0;
                case (ow_phase)
                    PH_LOW: begin
                        // write-zero slots have no sample point
                        ow_phase = (slot == SLOT_ZERO) ? PH_TAIL : PH_WAIT;
                    end
                    PH_WAIT: begin
                        if (slot == SLOT_RESET)
                            ow_presence = ~w.bus_level;
                        else if (ow_kind == KIND_READ_BIT)
                            ow_rx = {7'd0, w.bus_level};
                        else if (ow_kind == KIND_READ_BYTE || ow_kind == KIND_TOUCH_BYTE)
                            ow_rx = {w.bus_level, ow_rx[7:1]};
                        ow_phase = PH_TAIL;
                    end
                    default: begin
                        // a touch write-zero slot still moves a zero in
                        if (ow_kind == KIND_TOUCH_BYTE && slot == SLOT_ZERO)
                            ow_rx = ow_rx >> 1;
                        if (ow_kind >= KIND_WRITE_BYTE && ow_kind <= KIND_TOUCH_BYTE &&
                            ow_bit != LAST_BIT_INDEX) begin
                            ow_bit   = ow_bit + 3'd1;
                            ow_tx    = ow_tx >> 1;
                            ow_phase = PH_LOW;
                        end else begin
                            ow_phase   = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                    end
                endcase
            end else if (w.tick && ow_ticks != 16'hFFFF) begin
                ow_ticks = ow_ticks + 16'd1;
            end
        end
        r.drive_low   = (ow_phase == PH_LOW);
        r.busy_res    = (ow_phase != PH_IDLE);
        r.read_data   = ow_rx;
        r.no_presence = ~ow_presence;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input driver: bursts of random length with random gaps between
    // ------------------------------------------------------------------
    owbm_item_t on_bus_word;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // a word taken at this edge moves the shadow master on by one step
            if (s_tvalid && s_tready) begin
                master_outputs_due.push_back(advance_master(on_bus_word));
                words_unaccepted--;
            end
            // the word on the bus may only change once it has been taken
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (tx_words.size() > 0) begin
                    on_bus_word = tx_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'd0, on_bus_word.tick, on_bus_word.bus_level,
                                 on_bus_word.data_in, on_bus_word.start_req};
                    s_tuser  <= on_bus_word.kind;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // a quarter of the bursts run straight into the next one
                        burst_left = $urandom_range(4, 200);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor with its own ready pattern
    // ------------------------------------------------------------------
    int         ready_step = 0;
    logic [7:0] ready_mask = 8'hFF;

    always @(posedge aclk) begin : output_check
        owbm_result_t got;
        owbm_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[10:3], m_tdata[11]};
                if (master_outputs_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output word %0d arrived with nothing predicted: %h",
                                 results_seen, m_tdata);
                end else begin
                    want = master_outputs_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("output word %0d mismatch: want low=%b busy=%b",
                                     results_seen, want.drive_low, want.busy_res,
                                     " done=%b rd=%02h nopres=%b", want.done_res,
                                     want.read_data, want.no_presence);
                            $display("    got low=%b busy=%b done=%b rd=%02h nopres=%b",
                                     got.drive_low, got.busy_res, got.done_res,
                                     got.read_data, got.no_presence);
                        end
                    end
                end
                results_seen++;
            end
            // new ready pattern from an 8-bit mask now and then, some with no stalls at all
            ready_step = (ready_step + 1) % 64;
            if (ready_step == 0)
                ready_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom()) | 8'h11);
            m_tready <= ready_mask[ready_step % 8];
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic pick_bus(bus_drive_t sel);
        return (sel == BUS_RANDOM) ? 1'($urandom_range(0, 1)) : (sel == BUS_HIGH);
    endfunction

    task automatic queue_word(owbm_item_t w);
        tx_words.push_back(w);
        words_unaccepted++;
    endtask

    task automatic wait_drained();
        while (words_unaccepted != 0 || master_outputs_due.size() != 0)
            @(posedge aclk);
    endtask

    // feed ticking filler until the shadow master is idle and all words are back
    task automatic settle(bus_drive_t sel);
        owbm_item_t w;
        wait_drained();
        while (ow_phase != PH_IDLE) begin
            for (int i = 0; i < FILL_CHUNK; i++) begin
                w.start_req = 1'b0;
                w.kind      = 3'($urandom_range(0, 7));
                w.data_in   = 8'($urandom());
                w.bus_level = pick_bus(sel);
                w.tick      = ($urandom_range(0, 7) != 0);
                queue_word(w);
            end
            wait_drained();
        end
        // let the pipeline empty before any register write
        repeat (4) @(posedge aclk);
    endtask

    task automatic queue_start(logic [2:0] kind, logic [7:0] data, bus_drive_t sel);
        owbm_item_t w;
        w.start_req = 1'b1;
        w.kind      = kind;
        w.data_in   = data;
        w.bus_level = pick_bus(sel);
        w.tick      = 1'b1;
        queue_word(w);
    endtask

    task automatic send_cmd(logic [2:0] kind, logic [7:0] data, bus_drive_t sel);
        queue_start(kind, data, sel);
        settle(sel);
    endtask

    task automatic check_reg(logic [2:0] idx, logic [31:0] got, logic [15:0] want);
        if (got !== {16'd0, want}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("timing register %0d reads %h, want %h", idx, got, want);
        end
    endtask

    // read: setup then access, data taken at the access edge, then the bus returns to idle
    task automatic cfg_read(logic [2:0] idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // write with junk in the upper half, then read back straight away
    task automatic cfg_write(logic [2:0] idx, logic [15:0] value);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        ow_timing[idx] = value;
        cfg_read(idx, rd);
        check_reg(idx, rd, value);
    endtask

    task automatic load_timing(int lo, int hi);
        for (int i = 0; i < CFG_NUM; i++)
            cfg_write(3'(i), 16'($urandom_range(lo, hi)));
    endtask

    // random words: occasional starts, mostly valid kinds, ticks three in four
    task automatic random_run(int count);
        owbm_item_t w;
        for (int i = 0; i < count; i++) begin
            w.start_req = ($urandom_range(0, 5) == 0);
            w.kind      = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) :
                                                         3'($urandom_range(0, 5));
            w.data_in   = 8'($urandom());
            w.bus_level = 1'($urandom_range(0, 1));
            w.tick      = ($urandom_range(0, 3) != 0);
            queue_word(w);
        end
        settle(BUS_RANDOM);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] rd;
        ow_phase    = PH_IDLE;
        ow_ticks    = '0;
        ow_bit      = '0;
        ow_tx       = '0;
        ow_rx       = '0;
        ow_kind     = '0;
        ow_presence = 1'b0;
        for (int i = 0; i < CFG_NUM; i++)
            ow_timing[i] = CFG_RESET_VALUES[i];

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // timings must come out of reset at their defaults
        for (int i = 0; i < CFG_NUM; i++) begin
            cfg_read(3'(i), rd);
            check_reg(3'(i), rd, CFG_RESET_VALUES[i]);
        end

        // all timings zero: every phase ends on its first step
        load_timing(0, 0);
        send_cmd(KIND_RESET, 8'hFF, BUS_HIGH);      // no presence
        send_cmd(KIND_RESET, 8'h00, BUS_LOW);       // presence seen
        send_cmd(KIND_WRITE_BIT, 8'hFE, BUS_RANDOM); // only bit zero counts
        send_cmd(KIND_WRITE_BIT, 8'h01, BUS_RANDOM);
        send_cmd(KIND_READ_BIT, 8'h00, BUS_HIGH);
        send_cmd(KIND_READ_BIT, 8'hFF, BUS_LOW);
        send_cmd(KIND_WRITE_BYTE, 8'h00, BUS_RANDOM);
        send_cmd(KIND_WRITE_BYTE, 8'hFF, BUS_RANDOM);
        send_cmd(KIND_READ_BYTE, 8'h00, BUS_HIGH);
        send_cmd(KIND_READ_BYTE, 8'hFF, BUS_RANDOM);
        send_cmd(KIND_TOUCH_BYTE, 8'h5A, BUS_HIGH);
        send_cmd(KIND_TOUCH_BYTE, 8'hFF, BUS_LOW);
        send_cmd(KIND_TOUCH_BYTE, 8'h00, BUS_HIGH);  // all write-zero slots
        send_cmd(KIND_UNUSED_6, 8'hFF, BUS_RANDOM);
        send_cmd(KIND_UNUSED_7, 8'h00, BUS_RANDOM);
        // second start lands while the first command is running
        queue_start(KIND_READ_BYTE, 8'h3C, BUS_RANDOM);
        queue_start(KIND_WRITE_BYTE, 8'hC3, BUS_RANDOM);
        settle(BUS_RANDOM);

        // random words over several short timing sets
        load_timing(0, 3);
        random_run(600);
        load_timing(0, 12);
        random_run(600);
        load_timing(0, 1);
        random_run(400);

        // longer timings: a reset with a presence pulse and a write-zero slot
        load_timing(16, 48);
        send_cmd(KIND_RESET, 8'h00, BUS_LOW);
        send_cmd(KIND_WRITE_BIT, 8'h00, BUS_RANDOM);

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && master_outputs_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
